// ===== rtl/ihg_pkg.sv =====
// Shared types, constants and helper functions of the IPv4 header generator.
`timescale 1ns / 1ps

package ihg_pkg;

   localparam int unsigned HDR_WORDS     = 5;
   localparam int unsigned INDEX_W       = 3;
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(HDR_WORDS - 1);

   localparam logic [7:0]  VER_IHL       = 8'h45;
   localparam logic [7:0]  TTL_VALUE     = 8'd64;
   localparam logic [15:0] HDR_BYTES     = 16'd20;
   localparam logic [15:0] PAYLOAD_LIMIT = 16'd65515;

   localparam int unsigned REQ_DATA_W    = 120;
   localparam int unsigned RSP_DATA_W    = 56;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_TOO_LONG  = 2'd1,
      ERR_TOO_SMALL = 2'd2
   } err_type;

   // Fields that ride unchanged down the pipeline.
   typedef struct packed {
      logic [7:0]  protocol;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] identification;
   } fields_type;

   typedef struct packed {
      fields_type  fields;
      logic [16:0] total;
      logic [15:0] room;
      logic        too_long;
      logic [16:0] part_a;
      logic [16:0] part_b;
      logic [16:0] part_c;
   } stage1_type;

   typedef struct packed {
      fields_type  fields;
      logic [15:0] total;
      err_type     err;
      logic [18:0] sum;
   } stage2_type;

   typedef struct packed {
      fields_type  fields;
      logic [15:0] total;
      err_type     err;
      logic [16:0] fold;
   } stage3_type;

   // Moves the first octet (bits 7:0) to the top of the word, as sent on the wire.
   function automatic logic [31:0] wire_order(input logic [31:0] a);
      return {a[7:0], a[15:8], a[23:16], a[31:24]};
   endfunction

endpackage

// ===== rtl/ihg_pipe.sv =====
// Three-stage pipeline that checks lengths and computes the header sum up to its first carry fold.
`timescale 1ns / 1ps

module ihg_pipe
   import ihg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [REQ_DATA_W-1:0] in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output stage3_type            out_item
);

   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff;
   stage1_type s1_ff, s1_in;
   stage2_type s2_ff, s2_in;
   stage3_type s3_ff, s3_in;
   logic       s1_ready, s2_ready, s3_ready;
   fields_type in_fields;
   logic [15:0] in_plen, in_room;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign in_fields.protocol            = in_data[7:0];
   assign in_fields.source_address      = in_data[39:8];
   assign in_fields.destination_address = in_data[71:40];
   assign in_fields.identification      = in_data[87:72];
   assign in_plen                       = in_data[103:88];
   assign in_room                       = in_data[119:104];

   // Stage 1: total length, payload check and partial sums of the header halves.
   // The address halves are taken in wire order, first octet as the high byte.
   always_comb begin
      s1_in.fields   = in_fields;
      s1_in.total    = {1'b0, in_plen} + {1'b0, HDR_BYTES};
      s1_in.room     = in_room;
      s1_in.too_long = in_plen > PAYLOAD_LIMIT;
      s1_in.part_a   = 17'({VER_IHL, 8'h00}) + 17'(in_fields.identification)
                     + 17'({TTL_VALUE, in_fields.protocol});
      s1_in.part_b   = 17'({in_fields.source_address[7:0],
                            in_fields.source_address[15:8]})
                     + 17'({in_fields.source_address[23:16],
                            in_fields.source_address[31:24]});
      s1_in.part_c   = 17'({in_fields.destination_address[7:0],
                            in_fields.destination_address[15:8]})
                     + 17'({in_fields.destination_address[23:16],
                            in_fields.destination_address[31:24]});
   end

   // Stage 2: buffer check and the full sum.
   always_comb begin
      s2_in.fields = s1_ff.fields;
      s2_in.total  = s1_ff.total[15:0];
      if (s1_ff.too_long) begin
         s2_in.err = ERR_TOO_LONG;
      end else if ({1'b0, s1_ff.room} < s1_ff.total) begin
         s2_in.err = ERR_TOO_SMALL;
      end else begin
         s2_in.err = ERR_NONE;
      end
      s2_in.sum = 19'(s1_ff.total[15:0]) + 19'(s1_ff.part_a)
                + 19'(s1_ff.part_b) + 19'(s1_ff.part_c);
   end

   // Stage 3: first carry fold.
   always_comb begin
      s3_in.fields = s2_ff.fields;
      s3_in.total  = s2_ff.total;
      s3_in.err    = s2_ff.err;
      s3_in.fold   = 17'(s2_ff.sum[15:0]) + 17'(s2_ff.sum[18:16]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_ff <= s1_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_ff;

endmodule

// ===== rtl/ipv4_header_generator.sv =====
// Top level of the IPv4 header generator: checksum pipeline and word serializer.
`timescale 1ns / 1ps
//
// Each request word describes one datagram: protocol, source and destination
// addresses, identification, payload length and the room left in the buffer.
// For a valid datagram the block sends the 20-byte IPv4 header as five response
// words, word_index 0 to 4, with rsp_tlast on the fifth. When the payload is too
// long or the buffer too small, a single response word with a zero header, the
// error code and rsp_tlast is sent instead.
// A request passes the pipeline stages and the output register on its way to
// the first response word. Throughput is set by the 32-bit response port: a
// valid datagram holds it for five words, an error for one. Three pipeline
// stages (length checks and partial sums, full sum, first carry fold) plus the
// output register can hold four requests at once, so req_tready stays high
// while earlier ones are in work. When the receiver drops rsp_tready, the output
// word holds and the pipeline fills; req_tready falls only once every stage is
// occupied. Reset clears all valid bits; nothing is in flight afterwards.

module ipv4_header_generator
   import ihg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] protocol, [39:8] source_address, [71:40] destination_address,
   // [87:72] identification, [103:88] payload_length, [119:104] buffer_room
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] header_word, [34:32] word_index, [50:35] total_length,
   // [52:51] error_code, [55:53] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic        pipe_valid;
   logic        pipe_ready;
   stage3_type  pipe_item;

   logic              rsp_valid_ff;
   logic [31:0]       words_ff [HDR_WORDS];
   logic [31:0]       words_in [HDR_WORDS];
   logic [INDEX_W-1:0] index_ff;
   logic [15:0]       total_ff;
   err_type           err_ff;
   logic [15:0]       fold2;
   logic [15:0]       checksum;
   logic              rsp_fire;
   logic              load;

   ihg_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (pipe_valid),
      .out_ready (pipe_ready),
      .out_item  (pipe_item)
   );

   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign rsp_tlast  = (err_ff != ERR_NONE) || (index_ff == LAST_INDEX);
   // The next datagram loads as the final word of the current one leaves.
   assign pipe_ready = !rsp_valid_ff || (rsp_tready && rsp_tlast);
   assign load       = pipe_valid && pipe_ready;

   // Second carry fold and complement give the checksum field.
   assign fold2    = pipe_item.fold[15:0] + 16'(pipe_item.fold[16]);
   assign checksum = ~fold2;

   always_comb begin
      if (load) begin
         if (pipe_item.err != ERR_NONE) begin
            for (int i = 0; i < HDR_WORDS; i++) begin
               words_in[i] = '0;
            end
         end else begin
            words_in[0] = {VER_IHL, 8'h00, pipe_item.total};
            words_in[1] = {pipe_item.fields.identification, 16'h0000};
            words_in[2] = {TTL_VALUE, pipe_item.fields.protocol, checksum};
            words_in[3] = wire_order(pipe_item.fields.source_address);
            words_in[4] = wire_order(pipe_item.fields.destination_address);
         end
      end else begin
         // Shift toward the head so the next word sits at the port.
         for (int i = 0; i < HDR_WORDS - 1; i++) begin
            words_in[i] = words_ff[i+1];
         end
         words_in[HDR_WORDS-1] = words_ff[HDR_WORDS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire && rsp_tlast) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load || (rsp_fire && !rsp_tlast)) begin
         words_ff <= words_in;
      end
      if (load) begin
         index_ff <= '0;
         err_ff   <= pipe_item.err;
         total_ff <= (pipe_item.err == ERR_NONE) ? pipe_item.total : 16'h0000;
      end else if (rsp_fire && !rsp_tlast) begin
         index_ff <= index_ff + INDEX_W'(1);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, err_ff, total_ff, index_ff, words_ff[0]};

   // An error response is always a single, final word.
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[52:51] != ERR_NONE) |-> rsp_tlast)
      else $error("error response without tlast");

   // Error responses carry an all-zero header and length.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[52:51] != ERR_NONE) |->
      (rsp_tdata[50:0] == '0))
      else $error("error response with nonzero payload");

   // Inside a header the index steps by one and the length stays.
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
      rsp_tvalid && (rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1) &&
      (rsp_tdata[50:35] == $past(rsp_tdata[50:35])))
      else $error("header word index or length broke sequence");

   // A good header always ends at word four.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && (rsp_tdata[52:51] == ERR_NONE) |->
      (rsp_tdata[34:32] == LAST_INDEX))
      else $error("header ended before word four");

endmodule
